/* rtl/tmd_pkg.sv */
// Package for the trapezoid membership degree block.
// Holds the configuration register indexes, the result mode type and the default width.
// No dependencies.
package tmd_pkg;

	localparam int unsigned DATA_WIDTH_DEF = 16;
	localparam int unsigned CFG_INDEX_W = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_EDGE_LEFT         = 2'd0,
		REG_EDGE_CENTER_LEFT  = 2'd1,
		REG_EDGE_CENTER_RIGHT = 2'd2,
		REG_EDGE_RIGHT        = 2'd3
	} cfg_reg_t;

	// How the final degree is formed once the item leaves the divider.
	typedef enum logic [1:0] {
		MODE_ZERO  = 2'd0,
		MODE_ONE   = 2'd1,
		MODE_RATIO = 2'd2
	} deg_mode_t;

endpackage

/* rtl/trapezoid_membership_degree.sv */
// Top level of the trapezoid membership degree block: region decode, pipelined divider, output.
// Depends on tmd_pkg (register indexes, result mode type, default width).
//
//   channel   direction  handshake                 payload
//   in        to block   in_valid / in_stall       sample  (signed, DATA_WIDTH bits)
//   out       from block out_valid / out_stall     degree  (unsigned, DATA_WIDTH bits)
//   cfg       to block   cfg_we                    cfg_index, cfg_data
//
// One item is accepted per clock cycle while in_stall is low. An item passes one decode
// stage, DATA_WIDTH restoring divider stages that each resolve one quotient bit, and the
// output register. The divider stages set the latency; throughput is one item per cycle
// unless stalled. arst_n clears every valid bit and loads the breakpoints with their
// reset values. Each stage holds its item only while the stage ahead is full and cannot move,
// so empty stages close up behind a stalled output and no item is lost or repeated.
module trapezoid_membership_degree #(
	parameter int unsigned DATA_WIDTH = tmd_pkg::DATA_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                cfg_we,
	input  logic [tmd_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [DATA_WIDTH-1:0]               cfg_data,

	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [DATA_WIDTH-1:0]        sample,

	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [DATA_WIDTH-1:0]               degree
);

	import tmd_pkg::*;

	localparam int unsigned W = DATA_WIDTH;
	localparam int unsigned NDIV = DATA_WIDTH;

	// Unity in the degree format, and the breakpoint reset values derived from it.
	localparam logic [W-1:0] ONE_VAL = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] RST_LEFT = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] RST_CENTER_LEFT = {2'b11, {(W-2){1'b0}}};
	localparam logic [W-1:0] RST_CENTER_RIGHT = {2'b01, {(W-2){1'b0}}};
	localparam logic [W-1:0] RST_RIGHT = {1'b0, {(W-1){1'b1}}};

	// Breakpoint registers.
	logic signed [W-1:0] edge_left_q;
	logic signed [W-1:0] edge_center_left_q;
	logic signed [W-1:0] edge_center_right_q;
	logic signed [W-1:0] edge_right_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_left_q         <= RST_LEFT;
			edge_center_left_q  <= RST_CENTER_LEFT;
			edge_center_right_q <= RST_CENTER_RIGHT;
			edge_right_q        <= RST_RIGHT;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_EDGE_LEFT:         edge_left_q         <= cfg_data;
				REG_EDGE_CENTER_LEFT:  edge_center_left_q  <= cfg_data;
				REG_EDGE_CENTER_RIGHT: edge_center_right_q <= cfg_data;
				REG_EDGE_RIGHT:        edge_right_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipeline state.
	logic            v_s1;
	logic [W-1:0]    num_s1;
	logic [W-1:0]    den_s1;
	deg_mode_t       mode_s1;

	logic [NDIV-1:0] dv_s;
	logic [W:0]      dp_s [NDIV];
	logic [W-1:0]    dq_s [NDIV];
	logic [W-1:0]    dd_s [NDIV];
	deg_mode_t       dm_s [NDIV];

	logic            out_v_q;
	logic [W-1:0]    degree_q;

	// Ready chain: a stage may load when it is empty or the stage ahead is loading too.
	logic            rdy_out;
	logic [NDIV-1:0] drdy;
	logic            rdy_s1;

	always_comb begin
		rdy_out = !out_v_q || !out_stall;
		drdy[NDIV-1] = !dv_s[NDIV-1] || rdy_out;
		for (int k = NDIV - 2; k >= 0; k--) begin
			drdy[k] = !dv_s[k] || drdy[k+1];
		end
		rdy_s1 = !v_s1 || drdy[0];
	end

	assign in_stall = !rdy_s1;

	// Decode stage: locate the sample against the breakpoints and pick the edge to divide.
	logic signed [W:0] x_ext, l_ext, cl_ext, cr_ext, r_ext;
	logic signed [W:0] rise_num, rise_den, fall_num, fall_den;
	logic              l_eq_cl, cr_eq_r;
	logic              use_rise;
	deg_mode_t         mode_d;

	assign x_ext  = {sample[W-1], sample};
	assign l_ext  = {edge_left_q[W-1], edge_left_q};
	assign cl_ext = {edge_center_left_q[W-1], edge_center_left_q};
	assign cr_ext = {edge_center_right_q[W-1], edge_center_right_q};
	assign r_ext  = {edge_right_q[W-1], edge_right_q};

	assign rise_num = x_ext - l_ext;
	assign rise_den = cl_ext - l_ext;
	assign fall_num = r_ext - x_ext;
	assign fall_den = r_ext - cr_ext;

	assign l_eq_cl = (edge_left_q == edge_center_left_q);
	assign cr_eq_r = (edge_center_right_q == edge_right_q);

	always_comb begin
		mode_d = MODE_ZERO;
		use_rise = 1'b0;
		if (l_eq_cl && !cr_eq_r) begin
			// Left shoulder: flat from the left edge, falling toward the right edge.
			if (sample >= edge_left_q && sample <= edge_center_right_q) begin
				mode_d = MODE_ONE;
			end else if (sample >= edge_center_right_q && sample < edge_right_q) begin
				mode_d = MODE_RATIO;
			end
		end else if (cr_eq_r && !l_eq_cl) begin
			// Right shoulder: rising from the left edge, flat to the right edge.
			if (sample >= edge_center_left_q && sample <= edge_right_q) begin
				mode_d = MODE_ONE;
			end else if (sample > edge_left_q && sample <= edge_center_left_q) begin
				mode_d = MODE_RATIO;
				use_rise = 1'b1;
			end
		end else if (l_eq_cl && cr_eq_r) begin
			// Both edges vertical: a rectangle.
			if (sample >= edge_left_q && sample <= edge_right_q) begin
				mode_d = MODE_ONE;
			end
		end else begin
			if (sample < edge_left_q || sample >= edge_right_q) begin
				mode_d = MODE_ZERO;
			end else if (sample < edge_center_left_q) begin
				mode_d = MODE_RATIO;
				use_rise = 1'b1;
			end else if (sample < edge_center_right_q) begin
				mode_d = MODE_ONE;
			end else begin
				mode_d = MODE_RATIO;
			end
		end
	end

	// Any difference that a ratio degree uses is non-negative and below 2^W, so W bits hold it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			mode_s1 <= mode_d;
			num_s1  <= use_rise ? rise_num[W-1:0] : fall_num[W-1:0];
			den_s1  <= use_rise ? rise_den[W-1:0] : fall_den[W-1:0];
		end
	end

	// Restoring divider for num * 2^(W-1) / den with num <= den. Each stage compares the
	// partial remainder with the divisor, resolves one quotient bit from the top down, and
	// passes the doubled remainder on.
	for (genvar k = 0; k < NDIV; k++) begin : g_div
		logic         v_in;
		logic [W:0]   p_in;
		logic [W-1:0] q_in;
		logic [W-1:0] d_in;
		deg_mode_t    m_in;
		logic         ge;
		logic [W:0]   rem;

		if (k == 0) begin : g_first
			assign v_in = v_s1;
			assign p_in = {1'b0, num_s1};
			assign q_in = '0;
			assign d_in = den_s1;
			assign m_in = mode_s1;
		end else begin : g_next
			assign v_in = dv_s[k-1];
			assign p_in = dp_s[k-1];
			assign q_in = dq_s[k-1];
			assign d_in = dd_s[k-1];
			assign m_in = dm_s[k-1];
		end

		assign ge  = (p_in >= {1'b0, d_in});
		assign rem = ge ? (p_in - {1'b0, d_in}) : p_in;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[k] <= 1'b0;
			end else if (drdy[k]) begin
				dv_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (drdy[k] && v_in) begin
				dp_s[k] <= {rem[W-1:0], 1'b0};
				dq_s[k] <= {q_in[W-2:0], ge};
				dd_s[k] <= d_in;
				dm_s[k] <= m_in;
			end
		end
	end

	// Output register.
	logic [W-1:0] degree_d;

	always_comb begin
		case (dm_s[NDIV-1])
			MODE_ONE:   degree_d = ONE_VAL;
			MODE_RATIO: degree_d = dq_s[NDIV-1];
			default:    degree_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (rdy_out) begin
			out_v_q <= dv_s[NDIV-1];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && dv_s[NDIV-1]) begin
			degree_q <= degree_d;
		end
	end

	assign out_valid = out_v_q;
	assign degree = degree_q;

endmodule

/* tb/tmd_degree_checker.sv */
// Checker for the trapezoid membership degree block: predicts each degree and compares.
// Watches the configuration port and both item channels of the block; uses tmd_pkg.
// Hands its mismatch count and the number of degrees still awaited to the testbench top.
module tmd_degree_checker #(
	parameter int unsigned DATA_WIDTH = tmd_pkg::DATA_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tmd_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [DATA_WIDTH-1:0]             cfg_data,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic signed [DATA_WIDTH-1:0]      sample,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic [DATA_WIDTH-1:0]             degree,
	output int                                mismatches,
	output int                                pending
);

	localparam longint UNITY = longint'(1) << (DATA_WIDTH - 1);
	localparam int unsigned WIDE = 2 * DATA_WIDTH;
	localparam logic [DATA_WIDTH-1:0] FULL_DEGREE = DATA_WIDTH'(UNITY);
	localparam int REPORT_LIMIT = 10;

	typedef struct {
		logic signed [DATA_WIDTH-1:0] sample;
		logic [DATA_WIDTH-1:0]        degree;
	} graded_sample_t;

	logic signed [DATA_WIDTH-1:0] bp_left, bp_center_left, bp_center_right, bp_right;
	graded_sample_t awaited_degrees[$];
	graded_sample_t oldest;
	int faults = 0;

	// Share of the full degree covered by part out of whole, truncated.
	function automatic logic [DATA_WIDTH-1:0] scaled_share(input longint part, input longint whole);
		logic [WIDE-1:0] num;
		if (whole <= 0 || part <= 0)
			return '0;
		num = WIDE'(part) << (DATA_WIDTH - 1);
		return DATA_WIDTH'(num / WIDE'(whole));
	endfunction

	function automatic logic [DATA_WIDTH-1:0] membership_of(input logic signed [DATA_WIDTH-1:0] s);
		longint x, l, cl, cr, r;
		x = s;
		l = bp_left;
		cl = bp_center_left;
		cr = bp_center_right;
		r = bp_right;
		// Vertical left edge: flat from the left breakpoint through the end of the top.
		if (l == cl && cr != r) begin
			if (x >= l && x <= cr)
				return FULL_DEGREE;
			if (x >= cr && x < r)
				return scaled_share(r - x, r - cr);
			return '0;
		end
		// Vertical right edge: the mirror image.
		if (cr == r && l != cl) begin
			if (x >= cl && x <= r)
				return FULL_DEGREE;
			if (x > l && x <= cl)
				return scaled_share(x - l, cl - l);
			return '0;
		end
		// Both edges vertical: a rectangle, closed at both ends.
		if (l == cl && cr == r)
			return (x >= l && x <= r) ? FULL_DEGREE : '0;
		if (x < l || x >= r)
			return '0;
		if (x < cl)
			return scaled_share(x - l, cl - l);
		if (x < cr)
			return FULL_DEGREE;
		return scaled_share(r - x, r - cr);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bp_left <= DATA_WIDTH'(-UNITY);
			bp_center_left <= DATA_WIDTH'(-(UNITY / 2));
			bp_center_right <= DATA_WIDTH'(UNITY / 2);
			bp_right <= DATA_WIDTH'(UNITY - 1);
			awaited_degrees.delete();
			pending <= 0;
			mismatches <= faults;
		end else begin
			if (cfg_we) begin
				case (tmd_pkg::cfg_reg_t'(cfg_index))
					tmd_pkg::REG_EDGE_LEFT:         bp_left <= cfg_data;
					tmd_pkg::REG_EDGE_CENTER_LEFT:  bp_center_left <= cfg_data;
					tmd_pkg::REG_EDGE_CENTER_RIGHT: bp_center_right <= cfg_data;
					tmd_pkg::REG_EDGE_RIGHT:        bp_right <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				awaited_degrees.push_back('{sample, membership_of(sample)});
			if (out_valid && !out_stall) begin
				if (awaited_degrees.size() == 0) begin
					if (faults < REPORT_LIMIT)
						$display("unexpected degree %0d with no item outstanding", degree);
					faults++;
				end else begin
					oldest = awaited_degrees.pop_front();
					if (degree !== oldest.degree) begin
						if (faults < REPORT_LIMIT)
							$display("degree mismatch: sample %0d expected %0d got %0d",
								oldest.sample, oldest.degree, degree);
						faults++;
					end
				end
			end
			pending <= awaited_degrees.size();
			mismatches <= faults;
		end
	end

endmodule

/* tb/tb.sv */
// Testbench top for the trapezoid membership degree block: clock, reset, stimulus, verdict.
// Instantiates the block and tmd_degree_checker side by side; uses tmd_pkg.
module tb;

	localparam int unsigned DW = tmd_pkg::DATA_WIDTH_DEF;
	// Decode stage, one divider stage per quotient bit, and the output register.
	localparam int LATENCY = DW + 2;
	// Cycles with no item moving on either channel before the run is declared hung.
	localparam int STALL_LIMIT = 2000;
	// Length of the long output hold-off that fills the pipeline.
	localparam int HOLD_CYCLES = 80;
	localparam int SHAPE_COUNT = 10;
	localparam int RANDOM_SHAPES = 6;
	localparam int PHASE_ITEMS = 32;
	localparam int PRESSURE_ITEMS = 60;
	localparam logic signed [DW-1:0] SAMPLE_MIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic signed [DW-1:0] SAMPLE_MAX = {1'b0, {(DW-1){1'b1}}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [tmd_pkg::CFG_INDEX_W-1:0] cfg_index = tmd_pkg::REG_EDGE_LEFT;
	logic [DW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic signed [DW-1:0] sample = '0;
	logic out_stall = 1'b0;
	logic in_stall;
	logic out_valid;
	logic [DW-1:0] degree;

	int mismatches;
	int pending;

	// Idling knobs, in percent of cycles, changed by the stimulus between phases.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// The stimulus asks for a long hold-off by bumping holds_asked; the receiver
	// process grants it and counts the cycles down on its own.
	int holds_asked = 0;
	int holds_granted = 0;
	int hold_left = 0;

	int quiet_cycles = 0;

	// Breakpoints currently programmed, kept so that samples can aim at them.
	logic signed [DW-1:0] edges_now [4];

	// Samples graded under the reset breakpoints (-1.0, -0.5, 0.5, 1.0 - lsb):
	// both field extremes, each breakpoint and its neighbors, and mid-slope points.
	int reset_probes [15] = '{-32768, -32767, -24576, -16385, -16384, -16383, -1, 0, 1,
		16383, 16384, 16385, 24576, 32766, 32767};

	// Fixed shapes, one per row as left, center-left, center-right, right. They cover
	// a plain trapezoid, both shoulders, rectangles, triangles, the steepest possible
	// edges, and breakpoints given out of order.
	int shape_table [SHAPE_COUNT][4] = '{
		'{-20000, -5000, 3000, 25000},
		'{-32768, -32768, 0, 32767},
		'{-10000, 10000, 20000, 20000},
		'{-1000, -1000, 1000, 1000},
		'{-30000, 0, 0, 30000},
		'{-32768, -32767, 32766, 32767},
		'{-32768, 0, 0, 32767},
		'{-32768, -32768, 32767, 32767},
		'{10000, -10000, 5000, -5000},
		'{-10000, 20000, 0, 30000}
	};

	always #5 clk = ~clk;

	trapezoid_membership_degree #(
		.DATA_WIDTH(DW)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.degree(degree)
	);

	tmd_degree_checker #(
		.DATA_WIDTH(DW)
	) degree_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.degree(degree),
		.mismatches(mismatches),
		.pending(pending)
	);

	// Receiver side. A granted hold-off stalls the output for a fixed stretch;
	// otherwise each cycle stalls with the probability the current phase sets.
	always @(posedge clk) begin
		if (hold_left == 0 && holds_granted != holds_asked) begin
			hold_left = HOLD_CYCLES;
			holds_granted++;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else
			out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Watchdog: any cycle in which an item moves on either channel restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("** trapezoid_membership_degree: FAILED **");
			$finish;
		end
	end

	// Offers one item, after a random number of idle cycles, and returns once it is
	// accepted. Valid stays high on return so that back-to-back items leave no gap.
	task automatic offer_sample(input logic signed [DW-1:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// Stops offering items and waits until every outstanding degree has come back.
	// Since every item yields a degree, the block is then empty.
	task automatic drain_block();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input tmd_pkg::cfg_reg_t idx, input logic [DW-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic program_edges();
		drain_block();
		write_reg(tmd_pkg::REG_EDGE_LEFT, edges_now[0]);
		write_reg(tmd_pkg::REG_EDGE_CENTER_LEFT, edges_now[1]);
		write_reg(tmd_pkg::REG_EDGE_CENTER_RIGHT, edges_now[2]);
		write_reg(tmd_pkg::REG_EDGE_RIGHT, edges_now[3]);
		cfg_we <= 1'b0;
	endtask

	// 35 percent of samples land within two steps of a breakpoint, where the region tests
	// and the slope ends are decided; 10 percent are field extremes, 0 or -1, the rest uniform.
	function automatic logic signed [DW-1:0] pick_sample();
		int roll;
		int near;
		roll = $urandom_range(99);
		if (roll < 35) begin
			near = edges_now[$urandom_range(3)] + int'($urandom_range(4)) - 2;
			return DW'(near);
		end
		if (roll < 45) begin
			case ($urandom_range(3))
				0: return SAMPLE_MIN;
				1: return SAMPLE_MAX;
				2: return '0;
				default: return '1;
			endcase
		end
		return DW'($urandom());
	endfunction

	initial begin
		int k;
		int i;
		int j;
		logic signed [DW-1:0] swap;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items under the breakpoints that reset leaves behind.
		for (i = 0; i < 15; i++)
			offer_sample(DW'(reset_probes[i]));

		// One phase per shape. The idling pattern rotates from phase to phase, with some
		// phases left free of idling altogether.
		for (k = 0; k < SHAPE_COUNT + RANDOM_SHAPES; k++) begin
			case (k % 5)
				1: begin
					send_idle_pct = 83;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 83;
				end
				3: begin
					send_idle_pct = 10;
					recv_stall_pct = 10;
				end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			if (k < SHAPE_COUNT) begin
				for (j = 0; j < 4; j++)
					edges_now[j] = DW'(shape_table[k][j]);
			end else begin
				for (j = 0; j < 4; j++)
					edges_now[j] = DW'($urandom());
				// Most random shapes are put in order, sometimes with a vertical edge;
				// the last ones keep their breakpoints in whatever order they came.
				if (k < SHAPE_COUNT + 4) begin
					for (i = 0; i < 3; i++)
						for (j = 0; j < 3 - i; j++)
							if (edges_now[j] > edges_now[j+1]) begin
								swap = edges_now[j];
								edges_now[j] = edges_now[j+1];
								edges_now[j+1] = swap;
							end
					if ($urandom_range(3) == 0)
						edges_now[1] = edges_now[0];
					if ($urandom_range(3) == 0)
						edges_now[2] = edges_now[3];
				end
			end
			program_edges();
			for (i = 0; i < PHASE_ITEMS; i++)
				offer_sample(pick_sample());
		end

		// Back-pressure: the receiver holds off for a long stretch while the sender
		// keeps offering items, so the pipeline fills and the input stalls.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		holds_asked++;
		for (i = 0; i < PRESSURE_ITEMS; i++)
			offer_sample(pick_sample());

		drain_block();
		// Give any stray degree time to show up before the verdict.
		repeat (2 * LATENCY) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("** trapezoid_membership_degree: PASSED **");
		else
			$display("** trapezoid_membership_degree: FAILED **");
		$finish;
	end

endmodule

/* trapezoid_membership_degree.f */
rtl/tmd_pkg.sv
rtl/trapezoid_membership_degree.sv
tb/tmd_degree_checker.sv
tb/tb.sv
